>>> rtl/dmx_rdm_frame_receiver_unit_assert.svh
// Assertion macros for the DMX/RDM receiver.
`ifndef DMX_RDM_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define DMX_RDM_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DMX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DMX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/dmxrdm_pkg.sv
package dmxrdm_pkg;

   localparam int MaxFrameBytes = 513;
   localparam int PosWidth      = $clog2(MaxFrameBytes + 2);
   localparam int CfgWidth      = 10;
   localparam int CmpWidth      = (PosWidth > CfgWidth) ? PosWidth : CfgWidth;
   localparam int UidWidth      = 48;
   localparam int OffWidth      = 9;

   localparam int RdmMinLen     = 26;
   localparam int RdmMaxLen     = 257;
   localparam int MsgLenAdjust  = 2;
   localparam int PdlAdjust     = 26;
   localparam int PdlPos        = 23;
   localparam int SubPos        = 1;
   localparam int MsgLenPos     = 2;
   localparam int UidFirstPos   = 3;
   localparam int UidLastPos    = 8;

   localparam logic [7:0] ScDimmer   = 8'h00;
   localparam logic [7:0] ScRdm      = 8'hCC;
   localparam logic [7:0] SubMessage = 8'h01;
   localparam logic [7:0] Broadcast  = 8'hFF;

   localparam logic [1:0] CsrStartChannel = 2'd0;
   localparam logic [1:0] CsrSlotCount    = 2'd1;
   localparam logic [1:0] CsrDeviceUid    = 2'd2;

   localparam logic KindSlot    = 1'b0;
   localparam logic KindVerdict = 1'b1;

   localparam logic [1:0] StatusIgnored  = 2'd0;
   localparam logic [1:0] StatusChecksum = 2'd1;
   localparam logic [1:0] StatusLength   = 2'd2;
   localparam logic [1:0] StatusAccepted = 2'd3;

   localparam logic [CfgWidth-1:0] SlotCountReset = CfgWidth'(512);

   typedef logic [PosWidth-1:0] pos_type;
   typedef logic [CmpWidth-1:0] cmp_type;
   typedef logic [CfgWidth-1:0] cfg_type;
   typedef logic [UidWidth-1:0] uid_type;

endpackage

>>> rtl/dmx_rdm_frame_receiver_unit.sv
// DMX512 / RDM frame receiver.
// req_ channel: one received frame byte per item (req_data_byte), start code
// first, with req_frame_end high on the last byte of the frame.
// rsp_ channel: at most one item per byte. A dimmer frame (start code 0) gives
// a slot item for each byte inside the window set by start_channel and
// slot_count; an RDM frame (start code 0xCC) gives one verdict item on its
// last byte. Other start codes give nothing.
// csr_ channel: index 0 start_channel, 1 slot_count, 2 device_uid; always ready.
// The user must write it only while no byte is in flight; the block does not
// enforce this. Each byte is held in the input register and its result in the
// result register, which drives rsp_. Throughput: one byte per cycle, except
// that a byte with a result waits in the input register while rsp_ stalls.
// Reset clears the frame state, sets start_channel 0, slot_count 512 and
// device_uid 0. When the receiver stalls, the result register holds and the
// input stage keeps taking bytes until it holds a byte with a pending result;
// bytes that give no result never wait.
`include "dmx_rdm_frame_receiver_unit_assert.svh"

module dmx_rdm_frame_receiver_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_frame_end,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_result_kind,
   output logic [8:0]              rsp_slot_offset,
   output logic [7:0]              rsp_slot_value,
   output logic [1:0]              rsp_rdm_status,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [dmxrdm_pkg::UidWidth-1:0] csr_data
);
   import dmxrdm_pkg::*;

   logic          s1_valid_ff;
   logic [7:0]    s1_byte_ff;
   logic          s1_end_ff;

   pos_type       pos_ff;
   logic [7:0]    code_ff;
   logic          hdr_ok_ff;
   logic [7:0]    msg_len_ff;
   logic          own_ok_ff;
   logic          bcast_ok_ff;
   logic [15:0]   sum_ff;
   logic [7:0]    prev_ff;
   logic [7:0]    pdl_ff;

   cfg_type       start_ch_ff;
   cfg_type       slot_cnt_ff;
   uid_type       uid_ff;

   logic          rsp_valid_ff;
   logic          kind_ff;
   logic [8:0]    off_ff;
   logic [7:0]    val_ff;
   logic [1:0]    status_ff;

   logic          in_range;
   pos_type       pos_in;
   logic [7:0]    code_in;
   logic          hdr_ok_in;
   logic [7:0]    msg_len_in;
   logic          own_ok_in;
   logic          bcast_ok_in;
   logic [7:0]    pdl_in;
   logic [7:0]    uid_byte;
   cmp_type       slot_off;
   logic          slot_hit;
   logic          verdict_hit;
   logic          has_result;
   logic          out_free;
   logic          s1_advance;
   logic          len_ok;
   logic [15:0]   sum_expect;
   logic [15:0]   sum_got;
   logic [1:0]    status_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ch_ff <= '0;
         slot_cnt_ff <= SlotCountReset;
         uid_ff      <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CsrStartChannel: start_ch_ff <= csr_data[CfgWidth-1:0];
            CsrSlotCount:    slot_cnt_ff <= csr_data[CfgWidth-1:0];
            CsrDeviceUid:    uid_ff      <= csr_data;
            default:         ;
         endcase
      end
   end

   always_comb begin
      case (pos_ff)
         PosWidth'(UidFirstPos):     uid_byte = uid_ff[47:40];
         PosWidth'(UidFirstPos + 1): uid_byte = uid_ff[39:32];
         PosWidth'(UidFirstPos + 2): uid_byte = uid_ff[31:24];
         PosWidth'(UidFirstPos + 3): uid_byte = uid_ff[23:16];
         PosWidth'(UidFirstPos + 4): uid_byte = uid_ff[15:8];
         default:                    uid_byte = uid_ff[7:0];
      endcase
   end

   always_comb begin
      in_range    = pos_ff < PosWidth'(MaxFrameBytes);
      code_in     = code_ff;
      hdr_ok_in   = hdr_ok_ff;
      msg_len_in  = msg_len_ff;
      own_ok_in   = own_ok_ff;
      bcast_ok_in = bcast_ok_ff;
      pdl_in      = pdl_ff;
      if (in_range) begin
         if (pos_ff == '0) begin
            code_in = s1_byte_ff;
         end
         if (pos_ff == PosWidth'(SubPos)) begin
            hdr_ok_in = s1_byte_ff == SubMessage;
         end
         if (pos_ff == PosWidth'(MsgLenPos)) begin
            msg_len_in = s1_byte_ff;
         end
         if (pos_ff >= PosWidth'(UidFirstPos) && pos_ff <= PosWidth'(UidLastPos)) begin
            own_ok_in   = own_ok_ff & (s1_byte_ff == uid_byte);
            bcast_ok_in = bcast_ok_ff & (s1_byte_ff == Broadcast);
         end
         if (pos_ff == PosWidth'(PdlPos)) begin
            pdl_in = s1_byte_ff;
         end
      end
      pos_in = in_range ? pos_ff + PosWidth'(1) : PosWidth'(MaxFrameBytes + 1);
   end

   always_comb begin
      slot_off = CmpWidth'(pos_ff) - CmpWidth'(start_ch_ff);
      slot_hit = in_range && (code_in == ScDimmer) && (start_ch_ff != '0)
                 && (CmpWidth'(pos_ff) >= CmpWidth'(start_ch_ff))
                 && (slot_off < CmpWidth'(slot_cnt_ff))
                 && (slot_off < CmpWidth'(1 << OffWidth));
      verdict_hit = s1_end_ff && !slot_hit && (code_in == ScRdm);
      has_result  = slot_hit || verdict_hit;
   end

   always_comb begin
      len_ok = (CmpWidth'(pos_in) <= CmpWidth'(MaxFrameBytes))
               && (CmpWidth'(pos_in) >= CmpWidth'(RdmMinLen))
               && (CmpWidth'(pos_in) <= CmpWidth'(RdmMaxLen));
      sum_expect = sum_ff - {8'h00, prev_ff};
      sum_got    = {prev_ff, s1_byte_ff};
      if (!len_ok || !hdr_ok_in
          || (CmpWidth'(msg_len_in) + CmpWidth'(MsgLenAdjust) != CmpWidth'(pos_in))
          || (!own_ok_in && !bcast_ok_in)) begin
         status_in = StatusIgnored;
      end else if (sum_got != sum_expect) begin
         status_in = StatusChecksum;
      end else if (CmpWidth'(pdl_in) + CmpWidth'(PdlAdjust) != CmpWidth'(pos_in)) begin
         status_in = StatusLength;
      end else begin
         status_in = StatusAccepted;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && (!has_result || out_free);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_data_byte;
         s1_end_ff  <= req_frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (s1_advance && s1_end_ff)) begin
         pos_ff      <= '0;
         code_ff     <= '0;
         hdr_ok_ff   <= 1'b0;
         msg_len_ff  <= '0;
         own_ok_ff   <= 1'b1;
         bcast_ok_ff <= 1'b1;
         sum_ff      <= '0;
         prev_ff     <= '0;
         pdl_ff      <= '0;
      end else if (s1_advance) begin
         pos_ff      <= pos_in;
         code_ff     <= code_in;
         hdr_ok_ff   <= hdr_ok_in;
         msg_len_ff  <= msg_len_in;
         own_ok_ff   <= own_ok_in;
         bcast_ok_ff <= bcast_ok_in;
         pdl_ff      <= pdl_in;
         if (in_range) begin
            sum_ff  <= sum_ff + {8'h00, s1_byte_ff};
            prev_ff <= s1_byte_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && has_result) begin
         if (slot_hit) begin
            kind_ff   <= KindSlot;
            off_ff    <= slot_off[OffWidth-1:0];
            val_ff    <= s1_byte_ff;
            status_ff <= StatusIgnored;
         end else begin
            kind_ff   <= KindVerdict;
            off_ff    <= '0;
            val_ff    <= '0;
            status_ff <= status_in;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_slot_offset = off_ff;
   assign rsp_slot_value  = val_ff;
   assign rsp_rdm_status  = status_ff;

   `DMX_ASSERT_NOW(a_pos_bound, clock, reset, 1'b1,
      pos_ff <= PosWidth'(MaxFrameBytes + 1), "byte position out of range")
   `DMX_ASSERT_NEXT(a_frame_clear, clock, reset, s1_advance && s1_end_ff,
      pos_ff == '0 && own_ok_ff && bcast_ok_ff && sum_ff == '0, "frame state not cleared")
   `DMX_ASSERT_NOW(a_slot_status, clock, reset, rsp_valid && rsp_result_kind == KindSlot,
      rsp_rdm_status == StatusIgnored, "slot item carries a status")
   `DMX_ASSERT_NEXT(a_no_drop, clock, reset, rsp_valid_ff && !rsp_ready,
      rsp_valid_ff, "pending result dropped")

endmodule

>>> tb/sv/tb_dmx_rdm_frame_receiver_unit.sv
module tb_dmx_rdm_frame_receiver_unit;
   import dmxrdm_pkg::*;

   localparam int CycleLimit = 400_000;
   localparam int SlotLimit  = 1 << OffWidth;
   localparam int HoldCycles = 300;
   localparam int PhaseItems = 94;
   localparam int PhaseCount = 8;

   typedef struct packed {
      logic                kind;
      logic [OffWidth-1:0] offset;
      logic [7:0]          value;
      logic [1:0]          status;
   } rx_result_t;

   typedef enum {
      SHAPE_GOOD, SHAPE_BCAST, SHAPE_BAD_SUB, SHAPE_BAD_LEN,
      SHAPE_BAD_UID, SHAPE_BAD_SUM, SHAPE_BAD_PDL
   } rdm_shape_e;

   typedef enum {ROW_DIMMER, ROW_RDM, ROW_OTHER, ROW_CONFIG} row_kind_e;
   typedef enum {CHECK_MODEL, CHECK_NONE, CHECK_VERDICT} row_check_e;

   typedef struct {
      row_kind_e     kind;
      int unsigned   len;
      rdm_shape_e    shape;
      row_check_e    check;
      logic [1:0]    status;
      logic [1:0]    reg_index;
      uid_type       value;
   } plan_row_t;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [7:0]          req_data_byte;
   logic                req_frame_end;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_result_kind;
   logic [8:0]          rsp_slot_offset;
   logic [7:0]          rsp_slot_value;
   logic [1:0]          rsp_rdm_status;
   logic                csr_valid;
   logic                csr_ready;
   logic [1:0]          csr_index;
   logic [UidWidth-1:0] csr_data;

   cfg_type     cfg_start = '0;
   cfg_type     cfg_count = SlotCountReset;
   uid_type     cfg_uid   = '0;

   int unsigned rx_pos;
   logic [7:0]  rx_code;
   logic        rx_hdr_ok;
   logic [7:0]  rx_msg_len;
   logic        rx_own_ok;
   logic        rx_bcast_ok;
   logic [15:0] rx_sum;
   logic [7:0]  rx_prev;
   logic [7:0]  rx_pdl;

   rx_result_t  awaited[$];
   logic [7:0]  frame_bytes[$];
   int          mismatches     = 0;
   int          cycles         = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          holds_wanted   = 0;
   int          holds_taken    = 0;
   int          hold_left      = 0;

   plan_row_t plan [26] = '{
      '{ROW_DIMMER, 8,   SHAPE_GOOD,    CHECK_NONE,    StatusIgnored,  CsrStartChannel, '0},
      '{ROW_RDM,    26,  SHAPE_GOOD,    CHECK_VERDICT, StatusAccepted, CsrStartChannel, '0},
      '{ROW_OTHER,  5,   SHAPE_GOOD,    CHECK_NONE,    StatusIgnored,  CsrStartChannel, '0},
      '{ROW_CONFIG, 0,   SHAPE_GOOD,    CHECK_MODEL,   StatusIgnored,  CsrStartChannel, 48'd2},
      '{ROW_CONFIG, 0,   SHAPE_GOOD,    CHECK_MODEL,   StatusIgnored,  CsrSlotCount,    48'd4},
      '{ROW_CONFIG, 0,   SHAPE_GOOD,    CHECK_MODEL,   StatusIgnored,  CsrDeviceUid,
        48'h1234_5678_9ABC},
      '{ROW_DIMMER, 10,  SHAPE_GOOD,    CHECK_MODEL,   StatusIgnored,  CsrStartChannel, '0},
      '{ROW_DIMMER, 4,   SHAPE_GOOD,    CHECK_MODEL,   StatusIgnored,  CsrStartChannel, '0},
      '{ROW_DIMMER, 1,   SHAPE_GOOD,    CHECK_MODEL,   StatusIgnored,  CsrStartChannel, '0},
      '{ROW_RDM,    26,  SHAPE_BCAST,   CHECK_VERDICT, StatusAccepted, CsrStartChannel, '0},
      '{ROW_RDM,    257, SHAPE_GOOD,    CHECK_VERDICT, StatusAccepted, CsrStartChannel, '0},
      '{ROW_RDM,    26,  SHAPE_BAD_SUB, CHECK_VERDICT, StatusIgnored,  CsrStartChannel, '0},
      '{ROW_RDM,    30,  SHAPE_BAD_LEN, CHECK_VERDICT, StatusIgnored,  CsrStartChannel, '0},
      '{ROW_RDM,    26,  SHAPE_BAD_UID, CHECK_VERDICT, StatusIgnored,  CsrStartChannel, '0},
      '{ROW_RDM,    40,  SHAPE_BAD_SUM, CHECK_VERDICT, StatusChecksum, CsrStartChannel, '0},
      '{ROW_RDM,    40,  SHAPE_BAD_PDL, CHECK_VERDICT, StatusLength,   CsrStartChannel, '0},
      '{ROW_RDM,    25,  SHAPE_GOOD,    CHECK_VERDICT, StatusIgnored,  CsrStartChannel, '0},
      '{ROW_RDM,    258, SHAPE_GOOD,    CHECK_VERDICT, StatusIgnored,  CsrStartChannel, '0},
      '{ROW_RDM,    600, SHAPE_GOOD,    CHECK_VERDICT, StatusIgnored,  CsrStartChannel, '0},
      '{ROW_RDM,    1,   SHAPE_GOOD,    CHECK_VERDICT, StatusIgnored,  CsrStartChannel, '0},
      '{ROW_CONFIG, 0,   SHAPE_GOOD,    CHECK_MODEL,   StatusIgnored,  CsrStartChannel, 48'd1},
      '{ROW_CONFIG, 0,   SHAPE_GOOD,    CHECK_MODEL,   StatusIgnored,  CsrSlotCount,    48'd512},
      '{ROW_DIMMER, 513, SHAPE_GOOD,    CHECK_MODEL,   StatusIgnored,  CsrStartChannel, '0},
      '{ROW_DIMMER, 530, SHAPE_GOOD,    CHECK_MODEL,   StatusIgnored,  CsrStartChannel, '0},
      '{ROW_CONFIG, 0,   SHAPE_GOOD,    CHECK_MODEL,   StatusIgnored,  CsrStartChannel, 48'd512},
      '{ROW_DIMMER, 513, SHAPE_GOOD,    CHECK_MODEL,   StatusIgnored,  CsrStartChannel, '0}
   };

   dmx_rdm_frame_receiver_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_slot_offset (rsp_slot_offset),
      .rsp_slot_value  (rsp_slot_value),
      .rsp_rdm_status  (rsp_rdm_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #6 clock = ~clock;

   function automatic void clear_frame();
      rx_pos      = 0;
      rx_code     = '0;
      rx_hdr_ok   = 1'b0;
      rx_msg_len  = '0;
      rx_own_ok   = 1'b1;
      rx_bcast_ok = 1'b1;
      rx_sum      = '0;
      rx_prev     = '0;
      rx_pdl      = '0;
   endfunction

   function automatic logic [1:0] rdm_verdict_for(input int unsigned n, input logic [7:0] last_b);
      logic [15:0] want;
      logic [15:0] seen;
      if (n > MaxFrameBytes || n < RdmMinLen || n > RdmMaxLen) return StatusIgnored;
      if (!rx_hdr_ok || rx_msg_len != n - MsgLenAdjust) return StatusIgnored;
      if (!rx_own_ok && !rx_bcast_ok) return StatusIgnored;
      want = rx_sum - rx_prev;
      seen = {rx_prev, last_b};
      if (seen != want) return StatusChecksum;
      if (rx_pdl != n - PdlAdjust) return StatusLength;
      return StatusAccepted;
   endfunction

   function automatic bit take_frame_byte(input logic [7:0] b, input logic last,
                                          output rx_result_t r);
      int unsigned p;
      int unsigned off;
      bit          produced;
      p        = rx_pos;
      produced = 1'b0;
      r        = '0;
      if (p < MaxFrameBytes) begin
         if (p == 0) begin
            rx_code = b;
         end else if (p == SubPos) begin
            rx_hdr_ok = (b == SubMessage);
         end else if (p == MsgLenPos) begin
            rx_msg_len = b;
         end else if (p >= UidFirstPos && p <= UidLastPos) begin
            if (b != cfg_uid[8 * (UidLastPos - p) +: 8]) rx_own_ok = 1'b0;
            if (b != Broadcast) rx_bcast_ok = 1'b0;
         end else if (p == PdlPos) begin
            rx_pdl = b;
         end
         if (rx_code == ScDimmer && cfg_start != 0 && p >= cfg_start) begin
            off = p - cfg_start;
            if (off < cfg_count && off < SlotLimit) begin
               r        = '{KindSlot, off[OffWidth-1:0], b, StatusIgnored};
               produced = 1'b1;
            end
         end
         rx_pos = p + 1;
      end else begin
         rx_pos = MaxFrameBytes + 1;
      end
      if (last) begin
         if (!produced && rx_code == ScRdm) begin
            r        = '{KindVerdict, '0, '0, rdm_verdict_for(rx_pos, b)};
            produced = 1'b1;
         end
         clear_frame();
         return produced;
      end
      if (p < MaxFrameBytes) begin
         rx_sum  = rx_sum + b;
         rx_prev = b;
      end
      return produced;
   endfunction

   function automatic uid_type rand_uid();
      return uid_type'({$urandom, $urandom});
   endfunction

   function automatic void queue_dimmer(input int unsigned n);
      frame_bytes.push_back(ScDimmer);
      for (int i = 1; i < n; i++) frame_bytes.push_back(8'($urandom));
   endfunction

   function automatic void queue_other(input int unsigned n, input bit any_code);
      logic [7:0] code;
      code = 8'($urandom);
      while (!any_code && (code == ScDimmer || code == ScRdm)) code = 8'($urandom);
      frame_bytes.push_back(code);
      for (int i = 1; i < n; i++) frame_bytes.push_back(8'($urandom));
   endfunction

   function automatic void queue_rdm(input int unsigned n, input rdm_shape_e shape);
      logic [7:0]  f[];
      uid_type     dest;
      logic [15:0] csum;
      int          k;
      f = new[n];
      foreach (f[i]) f[i] = 8'($urandom);
      dest = (shape == SHAPE_BCAST) ? '1 : cfg_uid;
      if (shape == SHAPE_BAD_UID) begin
         k = $urandom_range(5);
         dest[8 * k +: 8] ^= 8'($urandom_range(1, 255));
      end
      f[0] = ScRdm;
      if (n > SubPos)
         f[SubPos] = (shape == SHAPE_BAD_SUB) ? 8'(SubMessage + $urandom_range(1, 254))
                                               : SubMessage;
      if (n > MsgLenPos)
         f[MsgLenPos] = 8'(n - MsgLenAdjust) ^ 8'(shape == SHAPE_BAD_LEN);
      for (int i = UidFirstPos; i <= UidLastPos && i < n; i++)
         f[i] = dest[8 * (UidLastPos - i) +: 8];
      if (n > PdlPos) f[PdlPos] = 8'(n - PdlAdjust) ^ 8'(shape == SHAPE_BAD_PDL);
      if (n >= 4) begin
         csum = '0;
         for (int i = 0; i < n - 2; i++) csum = csum + f[i];
         f[n - 2] = csum[15:8];
         f[n - 1] = csum[7:0] ^ 8'(shape == SHAPE_BAD_SUM);
      end
      foreach (f[i]) frame_bytes.push_back(f[i]);
   endfunction

   function automatic void queue_random_frame();
      int unsigned roll;
      int unsigned n;
      roll = $urandom_range(99);
      if (roll < 40) begin
         queue_dimmer(($urandom_range(19) == 0) ? $urandom_range(400, 530)
                                                : $urandom_range(1, 60));
      end else if (roll < 85) begin
         roll = $urandom_range(99);
         if (roll < 80)      n = $urandom_range(RdmMinLen, 40);
         else if (roll < 90) n = $urandom_range(41, RdmMaxLen);
         else if (roll < 95) n = RdmMaxLen;
         else                n = $urandom_range(1, 600);
         queue_rdm(n, ($urandom_range(1) == 0) ? SHAPE_GOOD
                                               : rdm_shape_e'($urandom_range(6)));
      end else begin
         queue_other($urandom_range(1, 30), 1'b1);
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last, input row_check_e check,
                            input logic [1:0] status);
      rx_result_t r;
      bit         produced;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_frame_end <= last;
      do @(posedge clock); while (!req_ready);
      produced = take_frame_byte(b, last, r);
      if (check == CHECK_VERDICT && last)
         awaited.push_back('{KindVerdict, '0, '0, status});
      else if (check != CHECK_NONE && produced)
         awaited.push_back(r);
      @(negedge clock);
   endtask

   task automatic send_queued(input row_check_e check, input logic [1:0] status);
      logic [7:0] b;
      while (frame_bytes.size() != 0) begin
         b = frame_bytes.pop_front();
         send_byte(b, frame_bytes.size() == 0, check, status);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (awaited.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input uid_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CsrStartChannel: cfg_start = val[CfgWidth-1:0];
         CsrSlotCount:    cfg_count = val[CfgWidth-1:0];
         CsrDeviceUid:    cfg_uid   = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input cfg_type start, input cfg_type count, input uid_type uid);
      write_reg(CsrStartChannel, uid_type'(start));
      write_reg(CsrSlotCount, uid_type'(count));
      write_reg(CsrDeviceUid, uid);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct, input bit hold);
      @(posedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (hold) holds_wanted++;
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (holds_taken != holds_wanted) begin
         holds_taken++;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rx_result_t want;
      rx_result_t seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_result_kind, rsp_slot_offset, rsp_slot_value, rsp_rdm_status};
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: kind %0d offset %0d value 0x%02h status %0d",
                        seen.kind, seen.offset, seen.value, seen.status);
         end else begin
            want = awaited.pop_front();
            if (seen.kind !== want.kind || seen.offset !== want.offset ||
                seen.value !== want.value || seen.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"item mismatch: expected kind %0d offset %0d value 0x%02h ",
                            "status %0d, got kind %0d offset %0d value 0x%02h status %0d"},
                           want.kind, want.offset, want.value, want.status,
                           seen.kind, seen.offset, seen.value, seen.status);
            end
         end
      end
   end

   initial begin
      clear_frame();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      req_frame_end = 1'b0;
      rsp_ready     = 1'b0;
      csr_valid     = 1'b0;
      csr_index     = CsrStartChannel;
      csr_data      = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_idling(18, 18, 1'b0);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CONFIG) begin
            settle();
            write_reg(plan[i].reg_index, plan[i].value);
         end else begin
            case (plan[i].kind)
               ROW_DIMMER: queue_dimmer(plan[i].len);
               ROW_RDM:    queue_rdm(plan[i].len, plan[i].shape);
               default:    queue_other(plan[i].len, 1'b0);
            endcase
            send_queued(plan[i].check, plan[i].status);
         end
      end

      // hold the receiver off while bytes keep coming so the block backs up
      settle();
      configure(cfg_type'(1), SlotCountReset, rand_uid());
      set_idling(0, 0, 1'b1);
      queue_dimmer(120);
      send_queued(CHECK_MODEL, StatusIgnored);

      for (int ph = 0; ph < PhaseCount; ph++) begin
         settle();
         case (ph)
            0: configure(cfg_type'(0), SlotCountReset, '1);
            1: configure(cfg_type'(1), SlotCountReset, rand_uid());
            2: configure(cfg_type'(512), cfg_type'(0), rand_uid());
            3: configure(cfg_type'(1), cfg_type'(0), '0);
            4: configure(cfg_type'($urandom_range(512)), cfg_type'($urandom_range(512)),
                         rand_uid());
            default: configure(cfg_type'($urandom_range(1, 40)),
                               cfg_type'($urandom_range(1, 60)), rand_uid());
         endcase
         set_idling((ph % 4 == 1) ? 71 : (ph % 4 == 3) ? 18 : 0,
                    (ph % 4 == 2) ? 71 : (ph % 4 == 3) ? 18 : 0, 1'b0);
         for (int i = 0; i < PhaseItems; i++) begin
            logic [7:0] b;
            if (frame_bytes.size() == 0) queue_random_frame();
            b = frame_bytes.pop_front();
            send_byte(b, frame_bytes.size() == 0, CHECK_MODEL, StatusIgnored);
         end
      end

      settle();
      repeat (8) @(negedge clock);
      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
